// ===== src/dmwc_pkg.sv =====
package dmwc_pkg;

   localparam int ENTRIES     = 32;
   localparam int SLOT_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int MAX_RESULTS = 32;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int CLUSTER_W   = 32;
   localparam int RSP_SLOT_W  = 5;
   localparam int REQ_TYPE_W  = 2;
   localparam int RSP_DATA_W  = 72;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_READ  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_FLUSH = 2'd2
   } req_kind_type;

   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_FLUSH = 1'b1
   } back_state_type;

   // one classified request held in the queue
   typedef struct packed {
      logic                 flush;
      logic                 write;
      logic [CLUSTER_W-1:0] cluster;
   } queue_item_type;

   // handshake between queue head and back end
   typedef struct packed {
      logic           valid;
      queue_item_type item;
   } queue_head_type;

   typedef struct packed {
      logic [CLUSTER_W-1:0]  fill_cluster;
      logic                  fill_needed;
      logic [CLUSTER_W-1:0]  writeback_cluster;
      logic                  writeback_needed;
      logic [RSP_SLOT_W-1:0] slot;
      logic                  hit;
   } rsp_type;

endpackage

// ===== src/direct_mapped_writeback_cache_ctrl.sv =====
// channel   | direction | payload
// req_      | in        | tdata: cluster; tuser: req_type
// rsp_      | out       | tdata: hit, slot, writeback, fill fields; tlast: last
// a read or write answers one per cycle unless a flush or a stalled response holds it
// a flush resets its scan, then answers each dirty entry in order up to the last one
// the two-deep request queue keeps accepting while the back end walks a flush
// reset clears valid and dirty bits at once, no clearing pass
// a stalled response holds the back end; the queue still takes requests until full
module direct_mapped_writeback_cache_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [dmwc_pkg::CLUSTER_W-1:0]      req_tdata,  // cluster
   input  logic [dmwc_pkg::REQ_TYPE_W-1:0]     req_tuser,  // req_type
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // hit, slot, writeback_needed, writeback_cluster, fill_needed, fill_cluster
   output logic [dmwc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast
);

   dmwc_pkg::queue_head_type head;
   logic                     pop;
   dmwc_pkg::rsp_type        rsp;

   dmwc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .head       (head),
      .pop        (pop)
   );

   dmwc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {rsp.fill_cluster, rsp.fill_needed, rsp.writeback_cluster,
                       rsp.writeback_needed, rsp.slot, rsp.hit};

   a_hit_no_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[39]))
      else $error("hit and fill both set");

   a_wb_cluster_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[6] |-> (rsp_tdata[38:7] == '0))
      else $error("writeback cluster without writeback");

   a_fill_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[39] |-> rsp_tlast)
      else $error("fill response not marked last");

endmodule

// ===== src/dmwc_front.sv =====
module dmwc_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [dmwc_pkg::CLUSTER_W-1:0]       req_tdata,
   input  logic [dmwc_pkg::REQ_TYPE_W-1:0]      req_tuser,
   output dmwc_pkg::queue_head_type             head,
   input  logic                                 pop
);

   dmwc_pkg::queue_item_type item_ff [dmwc_pkg::QUEUE_DEPTH];
   logic [dmwc_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [dmwc_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [dmwc_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                        accept;
   logic                        push;
   logic                        known;
   dmwc_pkg::queue_item_type    new_item;

   assign req_tready = (count_ff != dmwc_pkg::QCNT_W'(dmwc_pkg::QUEUE_DEPTH));
   assign accept     = req_tvalid && req_tready;

   // unused request code is dropped here
   assign known = req_tuser inside {dmwc_pkg::REQ_READ, dmwc_pkg::REQ_WRITE,
                                    dmwc_pkg::REQ_FLUSH};
   assign push  = accept && known;

   always_comb begin
      new_item.flush   = (req_tuser == dmwc_pkg::REQ_FLUSH);
      new_item.write   = (req_tuser == dmwc_pkg::REQ_WRITE);
      new_item.cluster = req_tdata;
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = item_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         item_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ===== src/dmwc_back.sv =====
module dmwc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  dmwc_pkg::queue_head_type  head,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output dmwc_pkg::rsp_type         rsp,
   output logic                      rsp_last
);

   localparam int N  = dmwc_pkg::ENTRIES;
   localparam int SW = dmwc_pkg::SLOT_W;

   dmwc_pkg::back_state_type state_ff, state_in;

   logic [N-1:0]                    valid_ff, dirty_ff;
   logic [dmwc_pkg::CLUSTER_W-1:0]  tag_ff [N];
   logic [SW-1:0]                   idx_ff, idx_in;
   logic [dmwc_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   dmwc_pkg::rsp_type               rsp_ff, rsp_in;
   logic                            last_ff, last_in;

   logic [N-1:0]                    vd, above;
   logic                            out_free;
   logic [SW-1:0]                   acc_slot, rd_idx;
   logic [dmwc_pkg::CLUSTER_W-1:0]  rd_tag;
   logic                            acc_hit;
   logic                            remaining;
   logic                            flush_last;
   logic                            load;
   logic                            do_access;
   logic                            clr_dirty;
   logic                            start_flush;
   logic                            advance;

   assign vd       = valid_ff & dirty_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign acc_slot = head.item.cluster[SW-1:0];
   assign rd_idx   = (state_ff == dmwc_pkg::ST_FLUSH) ? idx_ff : acc_slot;
   assign rd_tag   = tag_ff[rd_idx];
   assign acc_hit  = valid_ff[acc_slot] && (rd_tag == head.item.cluster);

   always_comb begin
      for (int j = 0; j < N; j++) begin
         above[j] = (SW'(j) > idx_ff);
      end
   end

   assign remaining  = |(vd & above);
   assign flush_last = !remaining ||
                       (cnt_ff == dmwc_pkg::CNT_W'(dmwc_pkg::MAX_RESULTS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dmwc_pkg::ST_IDLE: begin
            if (head.valid && out_free && head.item.flush && (vd != '0)) begin
               state_in = dmwc_pkg::ST_FLUSH;
            end
         end
         dmwc_pkg::ST_FLUSH: begin
            if (out_free && vd[idx_ff] && flush_last) begin
               state_in = dmwc_pkg::ST_IDLE;
            end
         end
         default: state_in = dmwc_pkg::ST_IDLE;
      endcase
   end

   // outputs and controls
   always_comb begin
      pop         = 1'b0;
      load        = 1'b0;
      do_access   = 1'b0;
      clr_dirty   = 1'b0;
      start_flush = 1'b0;
      advance     = 1'b0;
      rsp_in      = '0;
      last_in     = 1'b1;
      case (state_ff)
         dmwc_pkg::ST_IDLE: begin
            if (head.valid && out_free) begin
               pop = 1'b1;
               if (head.item.flush) begin
                  if (vd == '0) begin
                     load = 1'b1;
                  end else begin
                     start_flush = 1'b1;
                  end
               end else begin
                  load                       = 1'b1;
                  do_access                  = 1'b1;
                  rsp_in.hit                 = acc_hit;
                  rsp_in.slot                = dmwc_pkg::RSP_SLOT_W'(acc_slot);
                  rsp_in.writeback_needed    = !acc_hit && valid_ff[acc_slot] &&
                                               dirty_ff[acc_slot];
                  rsp_in.writeback_cluster   = rsp_in.writeback_needed ? rd_tag : '0;
                  rsp_in.fill_needed         = !acc_hit;
                  rsp_in.fill_cluster        = acc_hit ? '0 : head.item.cluster;
               end
            end
         end
         dmwc_pkg::ST_FLUSH: begin
            if (vd[idx_ff]) begin
               if (out_free) begin
                  load                     = 1'b1;
                  clr_dirty                = 1'b1;
                  advance                  = 1'b1;
                  rsp_in.slot              = dmwc_pkg::RSP_SLOT_W'(idx_ff);
                  rsp_in.writeback_needed  = 1'b1;
                  rsp_in.writeback_cluster = rd_tag;
                  last_in                  = flush_last;
               end
            end else begin
               advance = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      if (start_flush) begin
         idx_in = '0;
         cnt_in = '0;
      end else if (advance) begin
         idx_in = idx_ff + 1'b1;
         cnt_in = clr_dirty ? cnt_ff + 1'b1 : cnt_ff;
      end
      rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dmwc_pkg::ST_IDLE;
         valid_ff     <= '0;
         dirty_ff     <= '0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (do_access) begin
            valid_ff[acc_slot] <= 1'b1;
            dirty_ff[acc_slot] <= head.item.write || (acc_hit && dirty_ff[acc_slot]);
         end
         if (clr_dirty) begin
            dirty_ff[idx_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_access && !acc_hit) begin
         tag_ff[acc_slot] <= head.item.cluster;
      end
      if (load) begin
         rsp_ff  <= rsp_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign rsp_last  = last_ff;

endmodule

// ===== bench/cache_outcome_checker.sv =====
module cache_outcome_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [dmwc_pkg::CLUSTER_W-1:0]      req_tdata,  // cluster
   input  logic [dmwc_pkg::REQ_TYPE_W-1:0]     req_tuser,  // req_type
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // hit, slot, writeback_needed, writeback_cluster, fill_needed, fill_cluster
   input  logic [dmwc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                rsp_tlast,
   output int                                  mismatch_count,
   output int                                  outstanding
);
   import dmwc_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      rsp_type fields;
      logic    last;
   } outcome_type;

   outcome_type          expected_outcomes[$];
   logic                 line_valid [ENTRIES];
   logic                 line_dirty [ENTRIES];
   logic [CLUSTER_W-1:0] line_tag   [ENTRIES];
   outcome_type          got;
   outcome_type          want;

   task automatic clear_lines();
      for (int i = 0; i < ENTRIES; i++) begin
         line_valid[i] = 1'b0;
         line_dirty[i] = 1'b0;
         line_tag[i]   = '0;
      end
   endtask

   task automatic predict_access(input logic is_write, input logic [CLUSTER_W-1:0] cl);
      int          s;
      logic        hit;
      outcome_type o;
      s   = int'(cl % ENTRIES);
      hit = line_valid[s] && (line_tag[s] == cl);
      o   = '0;
      o.fields.hit  = hit;
      o.fields.slot = s[RSP_SLOT_W-1:0];
      o.last        = 1'b1;
      if (!hit) begin
         // dirty victim goes back to storage before the fill
         if (line_valid[s] && line_dirty[s]) begin
            o.fields.writeback_needed  = 1'b1;
            o.fields.writeback_cluster = line_tag[s];
         end
         line_valid[s] = 1'b1;
         line_dirty[s] = 1'b0;
         line_tag[s]   = cl;
         o.fields.fill_needed  = 1'b1;
         o.fields.fill_cluster = cl;
      end
      if (is_write) begin
         line_dirty[s] = 1'b1;
      end
      expected_outcomes.push_back(o);
   endtask

   task automatic predict_flush();
      int          n;
      outcome_type o;
      n = 0;
      for (int i = 0; i < ENTRIES && n < MAX_RESULTS; i++) begin
         if (line_valid[i] && line_dirty[i]) begin
            o = '0;
            o.fields.slot              = i[RSP_SLOT_W-1:0];
            o.fields.writeback_needed  = 1'b1;
            o.fields.writeback_cluster = line_tag[i];
            expected_outcomes.push_back(o);
            line_dirty[i] = 1'b0;
            n++;
         end
      end
      if (n == 0) begin
         o = '0;
         o.last = 1'b1;
         expected_outcomes.push_back(o);
      end else begin
         expected_outcomes[expected_outcomes.size()-1].last = 1'b1;
      end
   endtask

   task automatic note_failure(input string what, input outcome_type w, input outcome_type g);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%s: expected hit %0b slot %0d wb %0b %h fill %0b %h last %0b", what,
                  w.fields.hit, w.fields.slot, w.fields.writeback_needed,
                  w.fields.writeback_cluster, w.fields.fill_needed, w.fields.fill_cluster,
                  w.last);
         $display("%s: actual   hit %0b slot %0d wb %0b %h fill %0b %h last %0b", what,
                  g.fields.hit, g.fields.slot, g.fields.writeback_needed,
                  g.fields.writeback_cluster, g.fields.fill_needed, g.fields.fill_cluster,
                  g.last);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_lines();
         expected_outcomes.delete();
         mismatch_count = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               REQ_READ: begin
                  predict_access(1'b0, req_tdata);
               end
               REQ_WRITE: begin
                  predict_access(1'b1, req_tdata);
               end
               REQ_FLUSH: begin
                  predict_flush();
               end
               default: begin
               end
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.fields = rsp_type'(rsp_tdata);
            got.last   = rsp_tlast;
            if (expected_outcomes.size() == 0) begin
               note_failure("response with nothing outstanding", '0, got);
            end else begin
               want = expected_outcomes.pop_front();
               if (got !== want) begin
                  note_failure("response mismatch", want, got);
               end
            end
         end
      end
      outstanding <= expected_outcomes.size();
   end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
   import dmwc_pkg::*;

   localparam logic [REQ_TYPE_W-1:0] REQ_SPARE = 2'd3;
   localparam int DRAIN_CYCLES = 2 * ENTRIES + 16;
   localparam int UPPER_W      = CLUSTER_W - SLOT_W;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [CLUSTER_W-1:0]  req_tdata;
   logic [REQ_TYPE_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   int                    send_gap_pct  = 0;
   int                    rsp_stall_pct = 0;
   int                    mismatch_count;
   int                    outstanding;
   logic [UPPER_W-1:0]    upper_pool [4];

   direct_mapped_writeback_cache_ctrl i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   cache_outcome_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(20_000_000);
      $display("direct_mapped_writeback_cache_ctrl regression: fail");
      $finish;
   end

   initial begin
      forever begin
         @(negedge clock);
         rsp_tready = ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic issue_request(input logic [REQ_TYPE_W-1:0] kind,
                                input logic [CLUSTER_W-1:0] cl);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid = 1'b0;
         req_tdata  = $urandom;
         req_tuser  = REQ_TYPE_W'($urandom);
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = cl;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   function automatic logic [CLUSTER_W-1:0] pick_cluster();
      logic [SLOT_W-1:0] low;
      if ($urandom_range(99) < 15) begin
         return $urandom;
      end
      // few tags over few slots, so hits and dirty victims are common
      low = ($urandom_range(99) < 70) ? SLOT_W'($urandom_range(7))
                                      : SLOT_W'($urandom_range(ENTRIES-1));
      return {upper_pool[$urandom_range(3)], low};
   endfunction

   function automatic logic [REQ_TYPE_W-1:0] pick_kind();
      int r;
      r = $urandom_range(99);
      if (r < 45) begin
         return REQ_READ;
      end else if (r < 88) begin
         return REQ_WRITE;
      end else if (r < 97) begin
         return REQ_FLUSH;
      end
      return REQ_SPARE;
   endfunction

   // every slot dirty, then a flush of the largest size
   task automatic dirty_every_slot();
      logic [UPPER_W-1:0] upper;
      upper = upper_pool[$urandom_range(3)];
      for (int s = 0; s < ENTRIES; s++) begin
         issue_request(REQ_WRITE, {upper, SLOT_W'(s)});
      end
      issue_request(REQ_FLUSH, $urandom);
   endtask

   task automatic run_phase(input int gap_pct, input int stall_pct, input int n,
                            input logic with_sweep);
      send_gap_pct  = gap_pct;
      rsp_stall_pct = stall_pct;
      if (with_sweep) begin
         dirty_every_slot();
      end
      for (int i = 0; i < n; i++) begin
         issue_request(pick_kind(), pick_cluster());
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = REQ_READ;
      upper_pool[0] = '0;
      upper_pool[1] = UPPER_W'(1);
      upper_pool[2] = '1;
      upper_pool[3] = UPPER_W'($urandom);
      repeat (7) @(negedge clock);
      reset = 1'b0;

      issue_request(REQ_FLUSH, 32'h0);
      issue_request(REQ_READ, 32'h0);
      issue_request(REQ_READ, 32'h0);
      issue_request(REQ_WRITE, 32'h0);
      issue_request(REQ_WRITE, 32'h20);
      issue_request(REQ_READ, 32'h0);
      issue_request(REQ_WRITE, 32'hFFFF_FFFF);
      issue_request(REQ_WRITE, 32'h7FFF_FFFF);
      issue_request(REQ_READ, 32'hFFFF_FFFF);
      issue_request(REQ_WRITE, 32'h5);
      issue_request(REQ_WRITE, 32'hAAAA_AA0C);
      issue_request(REQ_SPARE, 32'h5555_5555);
      issue_request(REQ_FLUSH, 32'hFFFF_FFFF);
      issue_request(REQ_FLUSH, 32'h0);
      issue_request(REQ_WRITE, 32'h1);
      issue_request(REQ_READ, 32'h1);
      issue_request(REQ_SPARE, 32'h0);
      issue_request(REQ_READ, 32'h21);
      issue_request(REQ_FLUSH, 32'h0);

      run_phase(0, 0, 60, 1'b1);
      run_phase(82, 0, 80, 1'b0);
      run_phase(0, 82, 80, 1'b0);
      run_phase(16, 16, 60, 1'b1);

      req_tvalid = 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("direct_mapped_writeback_cache_ctrl regression: pass");
      end else begin
         $display("direct_mapped_writeback_cache_ctrl regression: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/dmwc_pkg.sv
src/dmwc_front.sv
src/dmwc_back.sv
src/direct_mapped_writeback_cache_ctrl.sv
bench/cache_outcome_checker.sv
bench/tb_top.sv
